FILE: hw/rtl/imtag_pkg.sv
// Shared types, constants and helpers of the im2col tap address generator.
package imtag_pkg;

  // Largest kernel height or width that the generator walks.
  localparam int MAX_KERNEL = 7;

  localparam int CFG_DW = 18;
  localparam int CFG_IW = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    REG_SRC_HEIGHT   = 3'd0,
    REG_SRC_WIDTH    = 3'd1,
    REG_SRC_CHANNELS = 3'd2,
    REG_KERNEL_SHAPE = 3'd3,
    REG_STEP_SHAPE   = 3'd4,
    REG_PADDING      = 3'd5,
    REG_ROW_LENGTH   = 3'd6
  } reg_idx_t;

  // Decoded configuration as the datapath sees it.
  typedef struct packed {
    logic [11:0] src_height;
    logic [11:0] src_width;
    logic [12:0] src_channels;
    logic [2:0]  kernel_y;
    logic [2:0]  kernel_x;
    logic [3:0]  stride_y;
    logic [3:0]  stride_x;
    logic [3:0]  dil_y;
    logic [3:0]  dil_x;
    logic [3:0]  pad_y;
    logic [3:0]  pad_x;
    logic [17:0] row_length;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_MULT,
    ST_TAP,
    ST_PAD,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic row_zero;
    logic row_enter;
    logic tap_start;
    logic tap_emit;
    logic row_adv;
    logic pad_emit;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ky_done;
    logic row_inside;
    logic kxs_zero;
    logic kx_last;
    logic pad_needed;
    logic gen_ok;
    logic pend_valid;
    logic out_free;
  } sts_t;

  function automatic logic [2:0] sat_kernel(input logic [2:0] k);
    logic [2:0] r;
    r = (int'(k) > MAX_KERNEL) ? 3'(MAX_KERNEL) : k;
    return r;
  endfunction

endpackage

FILE: hw/rtl/imtag_cfg.sv
// Configuration register file of the im2col tap address generator.
module imtag_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [imtag_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [imtag_pkg::CFG_DW-1:0]        cfg_data,
  output imtag_pkg::cfg_t                     cfg
);

  logic [11:0] height_r;
  logic [11:0] width_r;
  logic [12:0] channels_r;
  logic [5:0]  kshape_r;
  logic [15:0] step_r;
  logic [7:0]  padding_r;
  logic [17:0] rowlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r   <= 12'd1;
      width_r    <= 12'd1;
      channels_r <= 13'd1;
      kshape_r   <= 6'd9;
      step_r     <= 16'h1111;
      padding_r  <= 8'd0;
      rowlen_r   <= 18'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imtag_pkg::REG_SRC_HEIGHT:   height_r   <= cfg_data[11:0];
        imtag_pkg::REG_SRC_WIDTH:    width_r    <= cfg_data[11:0];
        imtag_pkg::REG_SRC_CHANNELS: channels_r <= cfg_data[12:0];
        imtag_pkg::REG_KERNEL_SHAPE: kshape_r   <= cfg_data[5:0];
        imtag_pkg::REG_STEP_SHAPE:   step_r     <= cfg_data[15:0];
        imtag_pkg::REG_PADDING:      padding_r  <= cfg_data[7:0];
        imtag_pkg::REG_ROW_LENGTH:   rowlen_r   <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.src_height   = height_r;
    cfg.src_width    = width_r;
    cfg.src_channels = channels_r;
    cfg.kernel_y     = imtag_pkg::sat_kernel(kshape_r[5:3]);
    cfg.kernel_x     = imtag_pkg::sat_kernel(kshape_r[2:0]);
    cfg.stride_y     = step_r[3:0];
    cfg.stride_x     = step_r[7:4];
    cfg.dil_y        = step_r[11:8];
    cfg.dil_x        = step_r[15:12];
    cfg.pad_y        = padding_r[3:0];
    cfg.pad_x        = padding_r[7:4];
    cfg.row_length   = rowlen_r;
  end

endmodule

FILE: hw/rtl/imtag_ctrl.sv
// Sequencing state machine of the im2col tap address generator.
module imtag_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  imtag_pkg::sts_t   sts,
  output imtag_pkg::cmd_t   cmd
);

  imtag_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imtag_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imtag_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = imtag_pkg::ST_ROW;
      end
      imtag_pkg::ST_ROW: begin
        if (sts.ky_done) begin
          state_nxt = imtag_pkg::ST_PAD;
        end else if (sts.row_inside && !sts.kxs_zero) begin
          state_nxt = imtag_pkg::ST_MULT;
        end
      end
      imtag_pkg::ST_MULT: state_nxt = imtag_pkg::ST_TAP;
      imtag_pkg::ST_TAP: begin
        if (sts.gen_ok && sts.kx_last) state_nxt = imtag_pkg::ST_ROW;
      end
      imtag_pkg::ST_PAD: begin
        if (!sts.pad_needed || sts.gen_ok) state_nxt = imtag_pkg::ST_FLUSH;
      end
      imtag_pkg::ST_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) state_nxt = imtag_pkg::ST_IDLE;
      end
      default: state_nxt = imtag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      imtag_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      imtag_pkg::ST_ROW: begin
        if (!sts.ky_done) begin
          if (!sts.row_inside) begin
            cmd.row_zero = sts.gen_ok;
            cmd.row_adv  = sts.gen_ok;
          end else if (sts.kxs_zero) begin
            cmd.row_adv = 1'b1;
          end else begin
            cmd.row_enter = 1'b1;
          end
        end
      end
      imtag_pkg::ST_MULT: cmd.tap_start = 1'b1;
      imtag_pkg::ST_TAP: begin
        cmd.tap_emit = sts.gen_ok;
        cmd.row_adv  = sts.gen_ok && sts.kx_last;
      end
      imtag_pkg::ST_PAD: cmd.pad_emit = sts.pad_needed && sts.gen_ok;
      imtag_pkg::ST_FLUSH: cmd.flush = sts.pend_valid && sts.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/imtag_dp.sv
// Coordinate, address and command datapath of the im2col tap address generator.
module imtag_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  imtag_pkg::cfg_t   cfg,
  input  imtag_pkg::cmd_t   cmd,
  output imtag_pkg::sts_t   sts,
  input  logic [10:0]       in_out_y,
  input  logic [10:0]       in_out_x,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [17:0]       out_dest_offset,
  output logic [33:0]       out_src_address,
  output logic [17:0]       out_length,
  output logic              out_zero_fill,
  output logic              out_last
);

  logic signed [16:0] sy_r, sy_nxt, sx0_r, sx0_nxt, sx_r, sx_nxt;
  logic [2:0]         ky_r, ky_nxt, kx_r, kx_nxt;
  logic [18:0]        dest_r, dest_nxt;
  logic signed [25:0] pix_r, pix_nxt;
  logic [33:0]        addr_r, addr_nxt;
  logic [15:0]        rowlen_r, rowlen_nxt;
  logic [16:0]        dstep_r, dstep_nxt;

  logic        pend_v_r, pend_v_nxt;
  logic [17:0] pend_dest_r, pend_dest_nxt;
  logic [33:0] pend_addr_r, pend_addr_nxt;
  logic [17:0] pend_len_r, pend_len_nxt;
  logic        pend_zero_r, pend_zero_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [17:0] out_dest_r, out_dest_nxt;
  logic [33:0] out_addr_r, out_addr_nxt;
  logic [17:0] out_len_r, out_len_nxt;
  logic        out_zero_r, out_zero_nxt;
  logic        out_last_r, out_last_nxt;

  logic [14:0]        ybase_prod, xbase_prod;
  logic signed [16:0] ybase, xbase;
  logic [23:0]        row_prod;
  logic signed [25:0] pix_calc;
  logic signed [39:0] mprod;
  logic               row_inside, col_inside, pad_needed, out_free, gen, move;
  logic [18:0]        pad_len;
  logic [17:0]        g_len;
  logic [33:0]        g_addr;
  logic               g_zero;

  assign ybase_prod = in_out_y * cfg.stride_y;
  assign xbase_prod = in_out_x * cfg.stride_x;
  assign ybase = $signed({2'b00, ybase_prod}) - $signed({13'd0, cfg.pad_y});
  assign xbase = $signed({2'b00, xbase_prod}) - $signed({13'd0, cfg.pad_x});

  // A source row inside the image is below 4096, so 12 bits carry it.
  assign row_prod = sy_r[11:0] * cfg.src_width;
  assign pix_calc = $signed({2'b00, row_prod}) + $signed({{9{sx0_r[16]}}, sx0_r});
  assign mprod    = pix_r * $signed({1'b0, cfg.src_channels});

  assign row_inside = !sy_r[16] && (sy_r[15:0] < {4'd0, cfg.src_height});
  assign col_inside = !sx_r[16] && (sx_r[15:0] < {4'd0, cfg.src_width});
  assign pad_needed = {1'b0, cfg.row_length} > dest_r;
  assign pad_len    = {1'b0, cfg.row_length} - dest_r;

  assign out_free = !out_valid_r || out_ready;
  assign gen      = cmd.row_zero || cmd.tap_emit || cmd.pad_emit;
  assign move     = (gen && pend_v_r) || cmd.flush;

  always_comb begin
    if (cmd.row_zero) begin
      g_len = {2'b00, rowlen_r};
    end else if (cmd.tap_emit) begin
      g_len = {5'd0, cfg.src_channels};
    end else begin
      g_len = pad_len[17:0];
    end
    g_zero = cmd.tap_emit ? !col_inside : 1'b1;
    g_addr = (cmd.tap_emit && col_inside) ? addr_r : 34'd0;
  end

  always_comb begin
    sy_nxt     = sy_r;
    sx0_nxt    = sx0_r;
    sx_nxt     = sx_r;
    ky_nxt     = ky_r;
    kx_nxt     = kx_r;
    dest_nxt   = dest_r;
    pix_nxt    = pix_r;
    addr_nxt   = addr_r;
    rowlen_nxt = rowlen_r;
    dstep_nxt  = dstep_r;
    if (cmd.load) begin
      sy_nxt     = ybase;
      sx0_nxt    = xbase;
      ky_nxt     = 3'd0;
      dest_nxt   = 19'd0;
      rowlen_nxt = 16'(cfg.kernel_x * cfg.src_channels);
      dstep_nxt  = 17'(cfg.dil_x * cfg.src_channels);
    end
    if (cmd.row_adv) begin
      ky_nxt = ky_r + 3'd1;
      sy_nxt = sy_r + $signed({13'd0, cfg.dil_y});
    end
    if (cmd.row_zero) dest_nxt = dest_r + {3'd0, rowlen_r};
    if (cmd.row_enter) pix_nxt = pix_calc;
    if (cmd.tap_start) begin
      addr_nxt = mprod[33:0];
      sx_nxt   = sx0_r;
      kx_nxt   = 3'd0;
    end
    if (cmd.tap_emit) begin
      dest_nxt = dest_r + {6'd0, cfg.src_channels};
      addr_nxt = addr_r + {17'd0, dstep_r};
      sx_nxt   = sx_r + $signed({13'd0, cfg.dil_x});
      kx_nxt   = kx_r + 3'd1;
    end
  end

  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_dest_nxt = pend_dest_r;
    pend_addr_nxt = pend_addr_r;
    pend_len_nxt  = pend_len_r;
    pend_zero_nxt = pend_zero_r;
    if (gen) begin
      pend_v_nxt    = 1'b1;
      pend_dest_nxt = dest_r[17:0];
      pend_addr_nxt = g_addr;
      pend_len_nxt  = g_len;
      pend_zero_nxt = g_zero;
    end else if (cmd.flush) begin
      pend_v_nxt = 1'b0;
    end

    out_dest_nxt = out_dest_r;
    out_addr_nxt = out_addr_r;
    out_len_nxt  = out_len_r;
    out_zero_nxt = out_zero_r;
    out_last_nxt = out_last_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_dest_nxt  = pend_dest_r;
      out_addr_nxt  = pend_addr_r;
      out_len_nxt   = pend_len_r;
      out_zero_nxt  = pend_zero_r;
      out_last_nxt  = cmd.flush;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sy_r        <= sy_nxt;
    sx0_r       <= sx0_nxt;
    sx_r        <= sx_nxt;
    ky_r        <= ky_nxt;
    kx_r        <= kx_nxt;
    dest_r      <= dest_nxt;
    pix_r       <= pix_nxt;
    addr_r      <= addr_nxt;
    rowlen_r    <= rowlen_nxt;
    dstep_r     <= dstep_nxt;
    pend_dest_r <= pend_dest_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_len_r  <= pend_len_nxt;
    pend_zero_r <= pend_zero_nxt;
    out_dest_r  <= out_dest_nxt;
    out_addr_r  <= out_addr_nxt;
    out_len_r   <= out_len_nxt;
    out_zero_r  <= out_zero_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    sts.ky_done    = (ky_r == cfg.kernel_y);
    sts.row_inside = row_inside;
    sts.kxs_zero   = (cfg.kernel_x == 3'd0);
    sts.kx_last    = (kx_r == (cfg.kernel_x - 3'd1));
    sts.pad_needed = pad_needed;
    sts.gen_ok     = !pend_v_r || out_free;
    sts.pend_valid = pend_v_r;
    sts.out_free   = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_dest_offset = out_dest_r;
  assign out_src_address = out_addr_r;
  assign out_length      = out_len_r;
  assign out_zero_fill   = out_zero_r;
  assign out_last        = out_last_r;

endmodule

FILE: hw/rtl/im2col_tap_address_generator.sv
// Top level of the im2col tap address generator: configuration, controller and datapath.
//
//   Channel   Direction  Handshake            Carries
//   in_       input      in_valid/in_ready    one output position (out_y, out_x)
//   out_      output     out_valid/out_ready  one copy or zero-fill command
//   cfg_      input      cfg_we only          one register write by index
//
// A position is loaded first. Then each kernel row that lies outside the image is zero-filled
// and each row with no taps is skipped; any other row runs the row-times-width and
// pixel-times-channels multiplies and then its taps. Last, the block checks, pads and flushes.
// Reset is synchronous and active low; it restores the register defaults and empties
// the command pipeline. A stalled result channel holds the controller at its next
// command, while the last finished command waits in the output register.
module im2col_tap_address_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [10:0]                    in_out_y,
  input  logic [10:0]                    in_out_x,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [17:0]                    out_dest_offset,
  output logic [33:0]                    out_src_address,
  output logic [17:0]                    out_length,
  output logic                           out_zero_fill,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [imtag_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [imtag_pkg::CFG_DW-1:0]   cfg_data
);

  imtag_pkg::cfg_t cfg;
  imtag_pkg::cmd_t cmd;
  imtag_pkg::sts_t sts;

  // Register file; writes are only expected while no transaction is in flight.
  imtag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The controller walks kernel rows and taps and issues one command at a time.
  imtag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath keeps one command pending so that the final one of a position
  // can be marked as last before it is handed to the output register.
  imtag_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_out_y        (in_out_y),
    .in_out_x        (in_out_x),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_dest_offset (out_dest_offset),
    .out_src_address (out_src_address),
    .out_length      (out_length),
    .out_zero_fill   (out_zero_fill),
    .out_last        (out_last)
  );

endmodule

FILE: hw/rtl/imtag_checker.sv
// Port-level assertions for the im2col tap address generator and their binding.
module imtag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [17:0] out_dest_offset,
  input logic [33:0] out_src_address,
  input logic [17:0] out_length,
  input logic        out_zero_fill,
  input logic        out_last
);

  // A stalled command keeps its whole payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_offset) &&
      $stable(out_src_address) && $stable(out_length) &&
      $stable(out_zero_fill) && $stable(out_last))
    else $error("result transaction changed while stalled");

  // After taking a position the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again straight after a transaction");

  // Reset leaves the block ready with nothing to deliver.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // Zero-fill commands never carry a source address.
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_fill |-> out_src_address == 34'd0)
    else $error("zero-fill command with non-zero source address");

endmodule

bind im2col_tap_address_generator imtag_checker u_imtag_checker (.*);
